@@ src/mspar_pkg.sv @@
// Shared types, codes and conversion functions for the multisample resolve framebuffer.
package mspar_pkg;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_RESOLVE = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_KIND   = 3'd2,
        CFG_TOTAL  = 3'd3,
        CFG_MS     = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ADDR,
        S_ACC,
        S_CLR,
        S_RS_RD,
        S_RS_CHK,
        S_RS_DIV,
        S_RS_WR,
        S_DONE
    } t_state;

    localparam logic [1:0] KIND_INT   = 2'd0;
    localparam logic [1:0] KIND_FIX   = 2'd1;
    localparam logic [1:0] KIND_UNORM = 2'd2;
    localparam logic [1:0] KIND_SNORM = 2'd3;

    localparam int WORD_W = 32;
    localparam int SUM_W  = 48;
    localparam int CNT_W  = 16;
    localparam int DIV_W  = 56;
    localparam int NUM_LANES = 4;

    // Signed result from sign and magnitude, saturated to the range of the format.
    function automatic logic [31:0] sat_word(input logic [1:0] kind, input logic neg,
                                             input logic [55:0] mag);
        logic [31:0] r;
        r = '0;
        case (kind)
            KIND_UNORM: begin
                r = neg ? 32'd0 : ((mag > 56'd255) ? 32'd255 : {24'd0, mag[7:0]});
            end
            KIND_SNORM: begin
                if (neg) begin
                    r = (mag > 56'd128) ? 32'hFFFF_FF80 : (32'd0 - mag[31:0]);
                end else begin
                    r = (mag > 56'd127) ? 32'd127 : mag[31:0];
                end
            end
            default: begin
                if (neg) begin
                    r = (mag > 56'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
                end else begin
                    r = (mag > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
                end
            end
        endcase
        return r;
    endfunction

    // Convert one supplied value to a stored word of the given kind.
    function automatic logic [31:0] conv_word(input logic [1:0] kind,
                                              input logic signed [31:0] v);
        logic [31:0] m;
        logic [39:0] s;
        m = v[31] ? (~$unsigned(v) + 32'd1) : $unsigned(v);
        case (kind)
            KIND_UNORM: s = ({8'd0, m} << 8) - {8'd0, m};
            KIND_SNORM: s = ({8'd0, m} << 7) - {8'd0, m};
            default:    s = {8'd0, m};
        endcase
        if (kind == KIND_UNORM || kind == KIND_SNORM) begin
            return sat_word(kind, v[31], 56'(s >> 16));
        end
        return sat_word(kind, v[31], 56'(s));
    endfunction

endpackage

@@ src/mspar_req_if.sv @@
// Request channel: operation, pixel coordinates and component values.
interface mspar_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
    logic [2:0]         value_count;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;

    modport source (output valid, opcode, pixel_x, pixel_y, value_count,
                    value_0, value_1, value_2, value_3, input ready);
    modport sink (input valid, opcode, pixel_x, pixel_y, value_count,
                  value_0, value_1, value_2, value_3, output ready);
endinterface

@@ src/mspar_rsp_if.sv @@
// Response channel: read components, sample count and status.
interface mspar_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_0;
    logic signed [31:0] read_1;
    logic signed [31:0] read_2;
    logic signed [31:0] read_3;
    logic [15:0]        samples_seen;
    logic               status;

    modport source (output valid, read_0, read_1, read_2, read_3, samples_seen, status,
                    input ready);
    modport sink (input valid, read_0, read_1, read_2, read_3, samples_seen, status,
                  output ready);
endinterface

@@ src/mspar_ram.sv @@
// Generic single-port RAM with registered read.
module mspar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                            i_wdata,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/multisample_pixel_accumulate_resolve.sv @@
// Framebuffer with multisample accumulation, frame clear and averaging resolve.
// Write and read: one request at a time.
// Clear: one pixel address per cycle; output words in the frame, sums and counts if multisample.
// Resolve (multisample only): pixels with samples get a bit-serial divide and a written result.
// Reset clears the sums and counts of every pixel before the first request is accepted;
// configuration writes are taken during that pass.
module multisample_pixel_accumulate_resolve
    import mspar_pkg::*;
#(
    parameter int MAX_WIDTH      = 128,
    parameter int MAX_HEIGHT     = 128,
    parameter int MAX_COMPONENTS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [7:0]   i_cfg_data,
    mspar_req_if.sink    i_req,
    mspar_rsp_if.source  o_rsp
);
    localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int PW     = $clog2(PIXELS + 1);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int NC     = MAX_COMPONENTS;

    t_state r_state, n_state;

    logic [7:0]  r_frame_width, r_frame_height;
    logic [1:0]  r_kind;
    logic [2:0]  r_total;
    logic        r_ms;

    t_op                r_op;
    logic [7:0]         r_x, r_y;
    logic signed [31:0] r_val [NUM_LANES];
    logic [AW-1:0]      r_idx;
    logic               r_oob;
    logic [PW-1:0]      r_ptr;
    logic [PW-1:0]      r_area;
    logic [5:0]         r_dcnt;
    logic [CNT_W-1:0]   r_den;
    logic [DIV_W-1:0]   r_dq  [NC];
    logic [CNT_W-1:0]   r_rem [NC];
    logic               r_neg [NC];

    logic               r_rsp_valid;
    logic [31:0]        r_rsp_rd [NUM_LANES];
    logic [CNT_W-1:0]   r_rsp_cnt;
    logic               r_rsp_st;

    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [2:0]     tot_eff;
    logic [AW-1:0]  idx_c;
    logic           oob_c;
    logic           accept;
    logic           rsp_load;
    logic           ptr_last;
    logic [NC-1:0]  lane_on;

    logic [AW-1:0]      m_addr;
    logic               m_re;
    logic [NC-1:0]      out_we, sum_we;
    logic               cnt_we;
    logic [31:0]        out_wdata [NC];
    logic [31:0]        out_rdata [NC];
    logic [SUM_W-1:0]   sum_wdata [NC];
    logic [SUM_W-1:0]   sum_rdata [NC];
    logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
    logic [31:0]        res_word [NC];
    logic [31:0]        rd_word [NUM_LANES];
    logic signed [31:0] in_val [NUM_LANES];

    assign w_eff   = (32'(r_frame_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_frame_width);
    assign h_eff   = (32'(r_frame_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_frame_height);
    assign tot_eff = (32'(r_total) > NC) ? 3'(NC) : r_total;
    assign idx_c   = AW'(32'(r_y) * 32'(w_eff) + 32'(r_x));
    assign oob_c   = (32'(r_x) >= 32'(w_eff)) || (32'(r_y) >= 32'(h_eff));
    assign ptr_last = (r_ptr == PW'(PIXELS - 1));
    assign accept  = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign in_val[0] = i_req.value_0;
    assign in_val[1] = i_req.value_1;
    assign in_val[2] = i_req.value_2;
    assign in_val[3] = i_req.value_3;

    assign cnt_wdata = (r_state == S_ACC && cnt_rdata != '1) ? cnt_rdata + 16'd1 :
                       (r_state == S_ACC) ? cnt_rdata : '0;

    mspar_ram #(.WIDTH(CNT_W), .DEPTH(PIXELS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_re    (m_re),
        .i_addr  (m_addr),
        .i_wdata (cnt_wdata),
        .o_rdata (cnt_rdata)
    );

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        if (c < NC) begin : g_on
            logic signed [SUM_W:0] s_add;
            logic [SUM_W-1:0]      s_mag;
            logic [DIV_W-1:0]      s_scl;
            logic [CNT_W:0]        d_try;
            logic                  d_ge;

            assign lane_on[c] = (3'(c) < tot_eff);

            assign s_add = {sum_rdata[c][SUM_W-1], sum_rdata[c]} + (SUM_W + 1)'(r_val[c]);
            assign sum_wdata[c] = (r_state != S_ACC) ? '0 :
                                  (s_add[SUM_W] == s_add[SUM_W-1]) ? s_add[SUM_W-1:0] :
                                  s_add[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} :
                                                 {1'b0, {(SUM_W - 1){1'b1}}};

            assign s_mag = sum_rdata[c][SUM_W-1] ? (~sum_rdata[c] + 48'd1) : sum_rdata[c];
            always_comb begin
                case (r_kind)
                    KIND_UNORM: s_scl = ({8'd0, s_mag} << 8) - {8'd0, s_mag};
                    KIND_SNORM: s_scl = ({8'd0, s_mag} << 7) - {8'd0, s_mag};
                    default:    s_scl = {8'd0, s_mag};
                endcase
            end

            assign d_try = {r_rem[c], r_dq[c][DIV_W-1]};
            assign d_ge  = (d_try >= {1'b0, r_den});

            assign res_word[c] = sat_word(r_kind, r_neg[c],
                (r_kind == KIND_UNORM || r_kind == KIND_SNORM) ? (r_dq[c] >> 16) : r_dq[c]);
            assign out_wdata[c] = (r_state == S_RS_WR) ? res_word[c]
                                                       : conv_word(r_kind, r_val[c]);
            assign rd_word[c] = out_rdata[c];

            always_ff @(posedge i_clk) begin
                if (r_state == S_RS_CHK) begin
                    r_dq[c]  <= s_scl;
                    r_rem[c] <= '0;
                    r_neg[c] <= sum_rdata[c][SUM_W-1];
                end else if (r_state == S_RS_DIV) begin
                    r_dq[c]  <= {r_dq[c][DIV_W-2:0], d_ge};
                    r_rem[c] <= d_ge ? CNT_W'(d_try - {1'b0, r_den}) : d_try[CNT_W-1:0];
                end
            end

            mspar_ram #(.WIDTH(WORD_W), .DEPTH(PIXELS)) u_out_ram (
                .i_clk   (i_clk),
                .i_we    (out_we[c]),
                .i_re    (m_re),
                .i_addr  (m_addr),
                .i_wdata (out_wdata[c]),
                .o_rdata (out_rdata[c])
            );

            mspar_ram #(.WIDTH(SUM_W), .DEPTH(PIXELS)) u_sum_ram (
                .i_clk   (i_clk),
                .i_we    (sum_we[c]),
                .i_re    (m_re),
                .i_addr  (m_addr),
                .i_wdata (sum_wdata[c]),
                .o_rdata (sum_rdata[c])
            );
        end else begin : g_off
            assign rd_word[c] = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:   if (ptr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_req.opcode))
                        OP_CLEAR:   n_state = S_CLR;
                        OP_RESOLVE: n_state = r_ms ? S_RS_RD : S_DONE;
                        default:    n_state = S_ADDR;
                    endcase
                end
            end
            S_ADDR:   n_state = (!oob_c && r_op == OP_WRITE && r_ms) ? S_ACC : S_DONE;
            S_ACC:    n_state = S_DONE;
            S_CLR:    if (ptr_last) n_state = S_DONE;
            S_RS_RD:  n_state = (r_ptr == r_area) ? S_DONE : S_RS_CHK;
            S_RS_CHK: n_state = (cnt_rdata == '0) ? S_RS_RD : S_RS_DIV;
            S_RS_DIV: if (r_dcnt == 6'(DIV_W - 1)) n_state = S_RS_WR;
            S_RS_WR:  n_state = S_RS_RD;
            S_DONE:   if (rsp_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        m_addr   = r_ptr[AW-1:0];
        m_re     = 1'b0;
        out_we   = '0;
        sum_we   = '0;
        cnt_we   = 1'b0;
        rsp_load = 1'b0;
        unique case (r_state)
            S_INIT: begin
                sum_we = '1;
                cnt_we = 1'b1;
            end
            S_ADDR: begin
                m_addr = idx_c;
                if (!oob_c) begin
                    if (r_op == OP_READ || r_ms) begin
                        m_re = 1'b1;
                    end else begin
                        out_we = lane_on;
                    end
                end
            end
            S_ACC: begin
                m_addr = r_idx;
                sum_we = lane_on;
                cnt_we = 1'b1;
            end
            S_CLR: begin
                out_we = (r_ptr < r_area) ? lane_on : '0;
                if (r_ms) begin
                    sum_we = '1;
                    cnt_we = 1'b1;
                end
            end
            S_RS_RD:  m_re = (r_ptr != r_area);
            S_RS_WR:  out_we = lane_on;
            S_DONE:   rsp_load = !r_rsp_valid || o_rsp.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_INIT;
            r_ptr          <= '0;
            r_rsp_valid    <= 1'b0;
            r_frame_width  <= 8'd128;
            r_frame_height <= 8'd128;
            r_kind         <= KIND_FIX;
            r_total        <= 3'd4;
            r_ms           <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_WIDTH:  r_frame_width  <= i_cfg_data;
                    CFG_HEIGHT: r_frame_height <= i_cfg_data;
                    CFG_KIND:   r_kind         <= i_cfg_data[1:0];
                    CFG_TOTAL:  r_total        <= i_cfg_data[2:0];
                    CFG_MS:     r_ms           <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_INIT, S_CLR: r_ptr <= ptr_last ? '0 : r_ptr + 1'b1;
                S_IDLE:        r_ptr <= '0;
                S_RS_CHK:      if (cnt_rdata == '0) r_ptr <= r_ptr + 1'b1;
                S_RS_WR:       r_ptr <= r_ptr + 1'b1;
                default: ;
            endcase
            if (rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= PW'(32'(w_eff) * 32'(h_eff));
        if (accept) begin
            r_op  <= t_op'(i_req.opcode);
            r_x   <= i_req.pixel_x;
            r_y   <= i_req.pixel_y;
            r_oob <= 1'b0;
            for (int c = 0; c < NUM_LANES; c++) begin
                r_val[c] <= (3'(c) < i_req.value_count) ? in_val[c] : 32'sd0;
            end
        end
        if (r_state == S_ADDR) begin
            r_idx <= idx_c;
            r_oob <= oob_c;
        end
        if (r_state == S_RS_CHK) begin
            r_den  <= cnt_rdata;
            r_dcnt <= '0;
        end else if (r_state == S_RS_DIV) begin
            r_dcnt <= r_dcnt + 6'd1;
        end
        if (rsp_load) begin
            for (int c = 0; c < NUM_LANES; c++) begin
                r_rsp_rd[c] <= (r_op == OP_READ && !r_oob && 3'(c) < tot_eff) ? rd_word[c] : '0;
            end
            r_rsp_cnt <= (r_op == OP_READ && !r_oob) ? cnt_rdata : '0;
            r_rsp_st  <= (r_op == OP_READ || r_op == OP_WRITE) && r_oob;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.read_0       = r_rsp_rd[0];
    assign o_rsp.read_1       = r_rsp_rd[1];
    assign o_rsp.read_2       = r_rsp_rd[2];
    assign o_rsp.read_3       = r_rsp_rd[3];
    assign o_rsp.samples_seen = r_rsp_cnt;
    assign o_rsp.status       = r_rsp_st;

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (out_we == '0 && sum_we == '0 && !cnt_we))
        else $error("memory write while idle");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RS_DIV) |-> (r_den != '0))
        else $error("resolve divide by zero count");

    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_load |=> (r_state == S_IDLE && r_rsp_valid))
        else $error("response load did not return to idle");
endmodule
